// ===== rtl/gspf_pkg.sv =====
// shared types and constants of the gait support phase state machine
package gspf_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned PRE_W   = 8;
    localparam int unsigned REF_W   = 16;
    localparam int unsigned THR_W   = 15;
    localparam int unsigned CFG_IDX_W = 3;

    localparam int unsigned IN_TDATA_W  = 88;
    localparam int unsigned OUT_TDATA_W = 88;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TICKS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DS_TICKS       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DS_TO_SS_TICKS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_BEFORE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_THRESHOLD  = 3'd4;

    // configuration reset values
    localparam logic [TIME_W-1:0]  STEP_TICKS_RST     = 32'd160;
    localparam logic [TIME_W-1:0]  DS_TICKS_RST       = 32'hFFFF_FFFF;
    localparam logic [TIME_W-1:0]  DS_TO_SS_TICKS_RST = 32'd160;
    localparam logic [COUNT_W-1:0] STEPS_BEFORE_RST   = 16'd200;
    localparam logic [THR_W-1:0]   REF_THRESHOLD_RST  = 15'd0;

    typedef enum logic {
        PHASE_DS = 1'b0,
        PHASE_SS = 1'b1
    } phase_t;

    typedef enum logic {
        FOOT_LEFT  = 1'b0,
        FOOT_RIGHT = 1'b1
    } foot_t;

    typedef struct packed {
        logic [TIME_W-1:0]  step_ticks;
        logic [TIME_W-1:0]  double_support_ticks;
        logic [TIME_W-1:0]  ds_to_ss_ticks;
        logic [COUNT_W-1:0] steps_before_stop;
        logic [THR_W-1:0]   ref_threshold;
    } gspf_cfg_t;

    typedef struct packed {
        logic signed [REF_W-1:0] ref_turn;
        logic signed [REF_W-1:0] ref_side;
        logic signed [REF_W-1:0] ref_fwd;
        logic [PRE_W-1:0]        preview_index;
        logic [TIME_W-1:0]       now_ticks;
    } gspf_item_t;

    typedef struct packed {
        phase_t             phase;
        foot_t              foot;
        logic [TIME_W-1:0]  limit;
        logic [COUNT_W-1:0] steps_left;
        logic [COUNT_W-1:0] step_count;
        logic [COUNT_W-1:0] instants;
    } gspf_state_t;

endpackage

// ===== rtl/gait_support_phase_fsm.sv =====
// top level of the gait support phase state machine
//
// usage
// - s_* channel: one beat per evaluation, tdata holds time, preview offset
//   and the three velocity reference components
// - m_* channel: exactly one result beat per input beat, in order, holding
//   the new phase, foot, limit, counters and a changed flag
// - cfg_* channel: register writes, always ready; write only while idle
// - each beat passes the input register, then the result register; one beat
//   per cycle sustained while m_tready stays high
// - the phase state advances when a beat moves from the input register into
//   the result register, so the next beat sees it in the following cycle
// - a stalled m_tready holds the result register; the input register still
//   takes one beat, after which s_tready drops until the result is taken
// - reset puts the machine in double support on the left foot with limit
//   and counters at zero, and loads the register defaults
// - a write to an index past the last register is accepted and dropped
module gait_support_phase_fsm (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // fields low to high: now_ticks[31:0], preview_index[39:32],
    // ref_fwd[55:40], ref_side[71:56], ref_turn[87:72]
    input  logic [gspf_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // fields low to high: phase_out[0], foot_out[1], limit_out[33:2],
    // steps_left_out[49:34], step_count_out[65:50], instants_out[81:66],
    // changed[82], zero pad[87:83]
    output logic [gspf_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [gspf_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gspf_pkg::TIME_W-1:0]          cfg_data
);
    import gspf_pkg::*;

    gspf_cfg_t   cfg_reg;
    gspf_state_t state_reg;
    gspf_state_t state_next;
    gspf_item_t  in_item_reg;
    logic        in_valid_reg;
    gspf_state_t out_state_reg;
    logic        out_changed_reg;
    logic        out_valid_reg;
    logic        changed_next;
    logic        out_advance;
    logic        eval;

    // configuration is always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_ticks           <= STEP_TICKS_RST;
            cfg_reg.double_support_ticks <= DS_TICKS_RST;
            cfg_reg.ds_to_ss_ticks       <= DS_TO_SS_TICKS_RST;
            cfg_reg.steps_before_stop    <= STEPS_BEFORE_RST;
            cfg_reg.ref_threshold        <= REF_THRESHOLD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_STEP_TICKS:     cfg_reg.step_ticks           <= cfg_data;
                CFG_DS_TICKS:       cfg_reg.double_support_ticks <= cfg_data;
                CFG_DS_TO_SS_TICKS: cfg_reg.ds_to_ss_ticks       <= cfg_data;
                CFG_STEPS_BEFORE:   cfg_reg.steps_before_stop    <= cfg_data[COUNT_W-1:0];
                CFG_REF_THRESHOLD:  cfg_reg.ref_threshold        <= cfg_data[THR_W-1:0];
                default:            ;
            endcase
        end
    end

    // result register moves when empty or when its beat is taken
    assign out_advance = !out_valid_reg || m_tready;
    assign s_tready    = !in_valid_reg || out_advance;
    assign eval        = in_valid_reg && out_advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg <= s_tdata;
        end
    end

    gspf_next u_next (
        .cfg     (cfg_reg),
        .item    (in_item_reg),
        .cur     (state_reg),
        .nxt     (state_next),
        .changed (changed_next)
    );

    // phase state, updated once per evaluated beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase      <= PHASE_DS;
            state_reg.foot       <= FOOT_LEFT;
            state_reg.limit      <= '0;
            state_reg.steps_left <= '0;
            state_reg.step_count <= '0;
            state_reg.instants   <= '0;
        end
        else if (eval)
        begin
            state_reg <= state_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eval)
        begin
            out_state_reg   <= state_next;
            out_changed_reg <= changed_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0,
                       out_changed_reg,
                       out_state_reg.instants,
                       out_state_reg.step_count,
                       out_state_reg.steps_left,
                       out_state_reg.limit,
                       out_state_reg.foot,
                       out_state_reg.phase};

endmodule

// ===== rtl/gspf_next.sv =====
// next-state logic of the support phase machine for one beat
module gspf_next (
    input  gspf_pkg::gspf_cfg_t   cfg,
    input  gspf_pkg::gspf_item_t  item,
    input  gspf_pkg::gspf_state_t cur,
    output gspf_pkg::gspf_state_t nxt,
    output logic                  changed
);
    import gspf_pkg::*;

    logic [REF_W-1:0]   mag_fwd;
    logic [REF_W-1:0]   mag_side;
    logic [REF_W-1:0]   mag_turn;
    logic               given;
    logic [TIME_W:0]    at_sum;
    logic [TIME_W:0]    short_sum;
    logic [TIME_W-1:0]  short_limit;
    logic               shorten;
    logic [TIME_W-1:0]  limit_mid;
    logic [COUNT_W-1:0] steps_mid;
    logic               hit;
    logic [TIME_W+1:0]  ds_sum;
    logic [TIME_W+1:0]  ss_sum;
    logic [TIME_W-1:0]  ds_limit;
    logic [TIME_W-1:0]  ss_limit;

    // magnitude of a two's complement value; most negative gives 32768
    function automatic logic [REF_W-1:0] magnitude(input logic signed [REF_W-1:0] v);
        logic [REF_W-1:0] r;
        begin
            r = v[REF_W-1] ? (~v + 1'b1) : v;
            return r;
        end
    endfunction

    // preview plus a duration can carry into the second extra bit
    function automatic logic [TIME_W-1:0] sat_limit(input logic [TIME_W+1:0] s);
        logic [TIME_W-1:0] r;
        begin
            r = (s[TIME_W+1:TIME_W] != 2'b00) ? {TIME_W{1'b1}} : s[TIME_W-1:0];
            return r;
        end
    endfunction

    always_comb
    begin
        mag_fwd  = magnitude(item.ref_fwd);
        mag_side = magnitude(item.ref_side);
        mag_turn = magnitude(item.ref_turn);
        given = (mag_fwd > {1'b0, cfg.ref_threshold}) ||
                (mag_side > {1'b0, cfg.ref_threshold}) ||
                (mag_turn > {1'b0, cfg.ref_threshold});

        at_sum    = {1'b0, item.now_ticks} + {{(TIME_W + 1 - PRE_W){1'b0}}, item.preview_index};
        short_sum = {1'b0, item.now_ticks} + {1'b0, cfg.ds_to_ss_ticks};
        short_limit = sat_limit({1'b0, short_sum});

        // a reference in double support pulls the limit in
        shorten = given && (cur.phase == PHASE_DS) && ({1'b0, cur.limit} > short_sum);
        limit_mid = shorten ? short_limit : cur.limit;
        steps_mid = shorten ? cfg.steps_before_stop : cur.steps_left;

        hit = at_sum >= {1'b0, limit_mid};

        ds_sum   = {1'b0, at_sum} + {2'b00, cfg.double_support_ticks};
        ss_sum   = {1'b0, at_sum} + {2'b00, cfg.step_ticks};
        ds_limit = sat_limit(ds_sum);
        ss_limit = sat_limit(ss_sum);
    end

    always_comb
    begin
        nxt            = cur;
        nxt.instants   = cur.instants + 1'b1;
        nxt.limit      = limit_mid;
        nxt.steps_left = steps_mid;
        changed        = 1'b0;
        if (hit)
        begin
            priority if (cur.phase == PHASE_SS && !given && steps_mid == '0)
            begin
                nxt.phase    = PHASE_DS;
                nxt.limit    = ds_limit;
                nxt.instants = '0;
                changed      = 1'b1;
            end
            else if (cur.phase == PHASE_DS && (given || steps_mid != '0))
            begin
                nxt.phase      = PHASE_SS;
                nxt.limit      = ss_limit;
                nxt.steps_left = cfg.steps_before_stop;
                nxt.instants   = '0;
                changed        = 1'b1;
            end
            else if ((cur.phase == PHASE_SS && steps_mid != '0) ||
                     (steps_mid == '0 && given))
            begin
                nxt.foot     = (cur.foot == FOOT_LEFT) ? FOOT_RIGHT : FOOT_LEFT;
                nxt.limit    = ss_limit;
                nxt.instants = '0;
                changed      = 1'b1;
                if (item.preview_index != 8'd1)
                begin
                    nxt.step_count = cur.step_count + 1'b1;
                end
                nxt.steps_left = given ? cfg.steps_before_stop : (steps_mid - 1'b1);
            end
            else
            begin
                // double support with no reference and no steps left: stay
            end
        end
    end

endmodule

// ===== tb/tb.sv =====
// self-checking testbench of the gait support phase state machine
module tb;
    import gspf_pkg::*;

    // indexes past the last register, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_PAST_LAST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_INDEX = 3'd7;

    localparam int HOLD_CYCLES = 80;    // long receiver hold-off
    localparam int DRAIN_LIMIT = 5000;  // cap on the final drain wait
    localparam int MAX_REPORTS = 10;

    // one predicted result beat: new state plus the changed flag
    typedef struct packed {
        gspf_state_t st;
        logic        changed;
    } gait_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [TIME_W-1:0]      cfg_data = '0;

    // items waiting for the driver, predicted results waiting for the monitor
    gspf_item_t   walk_items_q[$];
    gait_result_t gait_expect_q[$];

    // predictor copy of the phase state and of the register file
    gspf_state_t gait_st;
    gspf_cfg_t   cfg_sh;

    int pushed_cnt = 0;
    int accepted_cnt = 0;
    int result_cnt = 0;
    int change_cnt = 0;
    int mismatch_cnt = 0;
    int setting_cnt = 0;

    bit src_idle_on = 1'b0;
    bit sink_idle_on = 1'b0;
    bit hold_go = 1'b0;
    bit rx_hold = 1'b0;
    int src_gap = 0;
    int sink_gap = 0;

    // random walk of the time base and of the velocity command
    logic [TIME_W-1:0] walk_now = '0;
    int                walk_stride = 3;
    bit                cmd_on = 1'b0;

    always #5 clk = ~clk;

    gait_support_phase_fsm uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // saturate a 34 bit time sum at all ones
    function automatic logic [TIME_W-1:0] clip_time(input logic [TIME_W+1:0] v);
        return (v[TIME_W+1:TIME_W] != 2'b00) ? '1 : v[TIME_W-1:0];
    endfunction

    // a component counts when its magnitude is above the threshold,
    // the most negative value has magnitude 32768
    function automatic logic ref_active(input logic signed [REF_W-1:0] v,
                                        input logic [THR_W-1:0] thr);
        int mag;
        mag = (v < 0) ? -int'(v) : int'(v);
        return mag > int'(thr);
    endfunction

    // one evaluation of the phase machine on the predictor state
    function automatic void advance_gait(input gspf_item_t it, output gait_result_t r);
        logic [TIME_W:0] at_t;
        logic            given;
        given = ref_active(it.ref_fwd, cfg_sh.ref_threshold) ||
                ref_active(it.ref_side, cfg_sh.ref_threshold) ||
                ref_active(it.ref_turn, cfg_sh.ref_threshold);
        at_t = {1'b0, it.now_ticks} + {{(TIME_W-PRE_W+1){1'b0}}, it.preview_index};
        r.changed = 1'b0;
        gait_st.instants = gait_st.instants + 1'b1;

        // a command during double support pulls the limit in
        if (given && gait_st.phase == PHASE_DS &&
            {1'b0, gait_st.limit} > {1'b0, it.now_ticks} + {1'b0, cfg_sh.ds_to_ss_ticks})
        begin
            gait_st.limit = clip_time({2'b00, it.now_ticks} + {2'b00, cfg_sh.ds_to_ss_ticks});
            gait_st.steps_left = cfg_sh.steps_before_stop;
        end

        if (at_t >= {1'b0, gait_st.limit})
        begin
            if (gait_st.phase == PHASE_SS && !given && gait_st.steps_left == '0)
            begin
                // stop walking, back to double support
                gait_st.phase = PHASE_DS;
                gait_st.limit = clip_time({1'b0, at_t} + {2'b00, cfg_sh.double_support_ticks});
                r.changed = 1'b1;
                gait_st.instants = '0;
            end
            else if (gait_st.phase == PHASE_DS && (given || gait_st.steps_left != '0))
            begin
                // start walking
                gait_st.phase = PHASE_SS;
                gait_st.limit = clip_time({1'b0, at_t} + {2'b00, cfg_sh.step_ticks});
                gait_st.steps_left = cfg_sh.steps_before_stop;
                r.changed = 1'b1;
                gait_st.instants = '0;
            end
            else if ((gait_st.phase == PHASE_SS && gait_st.steps_left != '0) ||
                     (gait_st.steps_left == '0 && given))
            begin
                // next step on the other foot
                gait_st.foot = (gait_st.foot == FOOT_LEFT) ? FOOT_RIGHT : FOOT_LEFT;
                r.changed = 1'b1;
                gait_st.instants = '0;
                gait_st.limit = clip_time({1'b0, at_t} + {2'b00, cfg_sh.step_ticks});
                if (it.preview_index != 8'd1)
                    gait_st.step_count = gait_st.step_count + 1'b1;
                if (given)
                    gait_st.steps_left = cfg_sh.steps_before_stop;
                else
                    gait_st.steps_left = gait_st.steps_left - 1'b1;
            end
        end
        r.st = gait_st;
    endfunction

    // driver: offers queued items, predicts each one as its beat is taken
    always @(posedge clk or negedge rst_n)
    begin
        gait_result_t nxt;
        logic         offer;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                advance_gait(gspf_item_t'(s_tdata), nxt);
                gait_expect_q.push_back(nxt);
                accepted_cnt++;
            end
            // a beat on offer stays until taken
            if (!s_tvalid || s_tready)
            begin
                offer = 1'b0;
                if (src_gap > 0)
                    src_gap--;
                else if (walk_items_q.size() > 0)
                begin
                    if (src_idle_on && $urandom_range(0, 9) == 0)
                        src_gap = $urandom_range(0, 5);
                    else
                    begin
                        s_tdata <= walk_items_q.pop_front();
                        offer = 1'b1;
                    end
                end
                s_tvalid <= offer;
            end
        end
    end

    // monitor: checks each result beat against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        gait_result_t want;
        gait_result_t got;
        logic         ready_nxt;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                // unpack low to high: phase, foot, limit, steps left, step count,
                // instants, changed
                got.st.phase      = phase_t'(m_tdata[0]);
                got.st.foot       = foot_t'(m_tdata[1]);
                got.st.limit      = m_tdata[33:2];
                got.st.steps_left = m_tdata[49:34];
                got.st.step_count = m_tdata[65:50];
                got.st.instants   = m_tdata[81:66];
                got.changed       = m_tdata[82];
                result_cnt++;
                if (got.changed === 1'b1)
                    change_cnt++;
                if (gait_expect_q.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_REPORTS)
                        $display("result beat %0d arrived with nothing predicted: %h",
                                 result_cnt, m_tdata);
                end
                else
                begin
                    want = gait_expect_q.pop_front();
                    if (got !== want)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= MAX_REPORTS)
                            $display({"mismatch on result %0d (expected/actual): ",
                                      "phase %0d/%0d foot %0d/%0d limit %h/%h ",
                                      "steps_left %0d/%0d step_count %0d/%0d ",
                                      "instants %0d/%0d changed %0d/%0d"},
                                     result_cnt, want.st.phase, got.st.phase,
                                     want.st.foot, got.st.foot, want.st.limit, got.st.limit,
                                     want.st.steps_left, got.st.steps_left,
                                     want.st.step_count, got.st.step_count,
                                     want.st.instants, got.st.instants,
                                     want.changed, got.changed);
                    end
                end
            end
            // long hold-off first, then random stall bursts
            if (rx_hold)
                ready_nxt = 1'b0;
            else if (sink_gap > 0)
            begin
                sink_gap--;
                ready_nxt = 1'b0;
            end
            else if (sink_idle_on && $urandom_range(0, 7) == 0)
            begin
                sink_gap = $urandom_range(0, 5);
                ready_nxt = 1'b0;
            end
            else
                ready_nxt = 1'b1;
            m_tready <= ready_nxt;
        end
    end

    // long receiver hold-off, counted here so the sender keeps pushing
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // one register write, called on a rising edge
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_STEP_TICKS:     cfg_sh.step_ticks = val;
            CFG_DS_TICKS:       cfg_sh.double_support_ticks = val;
            CFG_DS_TO_SS_TICKS: cfg_sh.ds_to_ss_ticks = val;
            CFG_STEPS_BEFORE:   cfg_sh.steps_before_stop = val[COUNT_W-1:0];
            CFG_REF_THRESHOLD:  cfg_sh.ref_threshold = val[THR_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic program_regs(input logic [TIME_W-1:0] step, input logic [TIME_W-1:0] ds,
                                input logic [TIME_W-1:0] ds_to_ss,
                                input logic [TIME_W-1:0] stop, input logic [TIME_W-1:0] thr);
        write_reg(CFG_STEP_TICKS, step);
        write_reg(CFG_DS_TICKS, ds);
        write_reg(CFG_DS_TO_SS_TICKS, ds_to_ss);
        write_reg(CFG_STEPS_BEFORE, stop);
        write_reg(CFG_REF_THRESHOLD, thr);
        setting_cnt++;
    endtask

    // short steps and few steps so all transitions come often, junk in the
    // upper bits of the narrow registers
    task automatic program_random();
        program_regs($urandom_range(2, 10), $urandom_range(3, 24), $urandom_range(1, 8),
                     ($urandom & 32'hFFFF_0000) | $urandom_range(0, 4),
                     ($urandom & 32'hFFFF_8000) | $urandom_range(0, 3000));
    endtask

    task automatic queue_item(input logic [TIME_W-1:0] now, input logic [PRE_W-1:0] pre,
                              input logic [REF_W-1:0] fwd, input logic [REF_W-1:0] side,
                              input logic [REF_W-1:0] turn);
        gspf_item_t it;
        it.now_ticks     = now;
        it.preview_index = pre;
        it.ref_fwd       = fwd;
        it.ref_side      = side;
        it.ref_turn      = turn;
        walk_items_q.push_back(it);
        pushed_cnt++;
    endtask

    // mostly a forward moving clock with command bursts, some noise beats
    task automatic queue_walk(input int n);
        logic [TIME_W-1:0] now;
        logic [PRE_W-1:0]  pre;
        logic [REF_W-1:0]  comp [3];
        int                pick;
        int                lead;
        int                mag;
        int                thr;
        bit                neg;
        repeat (n)
        begin
            thr  = int'(cfg_sh.ref_threshold);
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 15) == 0)
                cmd_on = !cmd_on;
            if (pick < 3)
                walk_now = $urandom;
            else
                walk_now = walk_now + $urandom_range(0, walk_stride);
            now = walk_now;
            case ($urandom_range(0, 7))
                0, 1:    pre = 8'd0;
                2, 3:    pre = 8'd1;
                4, 5, 6: pre = 8'($urandom_range(2, 6));
                default: pre = 8'($urandom_range(0, 255));
            endcase
            lead = $urandom_range(0, 2);
            for (int k = 0; k < 3; k++)
            begin
                if (pick < 10)
                    comp[k] = $urandom;
                else
                begin
                    if (cmd_on && k == lead)
                        mag = $urandom_range(thr + 1, 32768);
                    else if ($urandom_range(0, 7) == 0)
                        mag = $urandom_range(0, 32768);
                    else
                        mag = $urandom_range(0, thr);
                    neg = (mag == 32768) || ($urandom_range(0, 1) == 1);
                    comp[k] = neg ? 16'(-mag) : 16'(mag);
                end
            end
            queue_item(now, pre, comp[0], comp[1], comp[2]);
        end
    endtask

    // pause the sender until every predicted result is back
    task automatic wait_drained();
        while (pushed_cnt != accepted_cnt || gait_expect_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // main sequence
    initial
    begin
        int guard;
        gait_st = '0;
        cfg_sh  = '{STEP_TICKS_RST, DS_TICKS_RST, DS_TO_SS_TICKS_RST,
                    STEPS_BEFORE_RST, REF_THRESHOLD_RST};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset state, nothing moves
        queue_item(32'd0, 8'd0, 16'd0, 16'd0, 16'd0);
        wait_drained();

        // directed walk through every transition on tiny durations
        program_regs(32'd4, 32'd6, 32'd3, 32'd1, 32'd16);
        queue_item(32'd10, 8'd0, 16'd0, 16'd0, 16'd0);    // idle in double support
        queue_item(32'd11, 8'd0, 16'd16, 16'd0, 16'd0);   // at threshold, not given
        queue_item(32'd12, 8'd0, 16'd17, 16'd0, 16'd0);   // ds to ss
        queue_item(32'd14, 8'd0, 16'd0, 16'd0, 16'd0);
        queue_item(32'd16, 8'd1, 16'd0, 16'd0, 16'd0);    // swap, preview of one
        queue_item(32'd21, 8'd0, 16'd0, 16'd0, 16'd0);    // ss to ds, no steps left
        queue_item(32'd22, 8'd0, 16'd0, 16'd0, 16'd0);
        queue_item(32'd22, 8'd0, 16'd0, -16'sd17, 16'd0); // limit shortened
        queue_item(32'd23, 8'd0, 16'd0, 16'd0, 16'h8000); // most negative counts
        queue_item(32'd20, 8'd5, 16'd0, 16'd0, 16'd0);    // reached through preview
        queue_item(32'd29, 8'd0, 16'd0, 16'd0, 16'd100);  // swap with reload
        queue_item(32'd40, 8'd0, 16'd0, 16'd0, 16'd0);    // swap counting down
        queue_item(32'd44, 8'd0, 16'd50, 16'd0, 16'd0);   // no steps left but a command
        queue_item(32'd100, 8'd0, 16'd0, 16'd0, 16'd0);
        queue_item(32'd200, 8'd0, 16'd0, 16'd0, 16'd0);
        queue_item(32'd300, 8'd0, 16'd0, 16'd0, 16'd0);   // past the limit, nothing to do
        queue_item(32'd300, 8'd0, 16'd1000, 16'd0, 16'd0); // past the limit, no shortening
        wait_drained();

        // directed extremes: saturated sums, full threshold
        program_regs(STEP_TICKS_RST, DS_TICKS_RST, DS_TO_SS_TICKS_RST, 32'd0, 32'd32767);
        queue_item(32'hFFFF_FFFF, 8'd255, 16'd0, 16'd0, 16'd0);
        queue_item(32'hFFFF_FF00, 8'd255, 16'd0, 16'd0, 16'd0);
        queue_item(32'd0, 8'd0, 16'h8000, 16'd0, 16'd0);
        queue_item(32'd0, 8'd200, 16'd0, 16'h7FFF, 16'd0);
        queue_item(32'd1000, 8'd0, 16'd0, 16'd0, 16'h8000);
        queue_item(32'd1160, 8'd1, 16'd0, 16'd0, 16'd0);
        wait_drained();

        // random walking on short steps with idling on both sides
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        program_random();
        walk_now    = $urandom_range(0, 1000);
        walk_stride = 3;
        queue_walk(130);
        wait_drained();

        // receiver holds off while the sender keeps offering beats
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        hold_go      = 1'b1;
        queue_walk(60);
        wait_drained();

        // shortest durations, zero threshold, plus dropped writes past the last index
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        program_regs(32'd1, 32'd1, 32'd1, 32'd0, 32'd0);
        write_reg(CFG_PAST_LAST, '1);
        write_reg(CFG_TOP_INDEX, '1);
        walk_stride = 2;
        queue_walk(100);
        wait_drained();

        program_random();
        walk_stride = 3;
        queue_walk(130);
        wait_drained();

        // power-on values, wide time strides
        program_regs(STEP_TICKS_RST, DS_TICKS_RST, DS_TO_SS_TICKS_RST,
                     STEPS_BEFORE_RST, REF_THRESHOLD_RST);
        walk_stride = 40;
        queue_walk(120);
        wait_drained();

        // last part runs without idling
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        program_random();
        walk_stride = 3;
        queue_walk(130);
        wait_drained();

        // largest values near the top of the time range
        program_regs('1, '1, '1, '1, '1);
        walk_now    = 32'hFFFF_F000;
        walk_stride = 150;
        queue_walk(50);

        guard = 0;
        while ((pushed_cnt != accepted_cnt || gait_expect_q.size() != 0) && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
        if (gait_expect_q.size() != 0)
        begin
            $display("%0d predicted results never arrived", gait_expect_q.size());
            mismatch_cnt += gait_expect_q.size();
        end

        $display("covered %0d evaluations over %0d register settings, %0d phase or foot changes",
                 accepted_cnt, setting_cnt, change_cnt);
        $display("%0d result beats checked, %0d mismatches", result_cnt, mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    // watchdog
    initial
    begin
        #3_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
